@@ rtl/clock_24h_seven_segment_with_set_top_assert.svh @@
// Assertion macros shared by clk24_time and the top module of the clock.
`ifndef CLOCK_24H_SEVEN_SEGMENT_WITH_SET_TOP_ASSERT_SVH
`define CLOCK_24H_SEVEN_SEGMENT_WITH_SET_TOP_ASSERT_SVH

// Checked on every rising edge of clk_i, masked while rst_ni is low.
`define CLK24_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define CLK24_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/clk24_pkg.sv @@
// Shared types, constants and decode functions of the 24-hour clock.
package clk24_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgTicksPerSecond = 2'd0;
  localparam logic [1:0] CfgTickReload     = 2'd1;
  localparam logic [1:0] CfgBlinkHalf      = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] TicksPerSecondReset = 16'd1000;
  localparam logic [15:0] TickReloadReset     = 16'd30;
  localparam logic [7:0]  BlinkHalfReset      = 8'd10;

  // Field selection codes.
  localparam logic [1:0] FieldNone    = 2'd0;
  localparam logic [1:0] FieldMinutes = 2'd1;
  localparam logic [1:0] FieldHours   = 2'd2;

  localparam logic [5:0] SecondsPerMinute = 6'd60;
  localparam logic [5:0] MinutesPerHour   = 6'd60;
  localparam logic [4:0] HoursPerDay      = 5'd24;

  typedef struct packed {
    logic [15:0] ticks_per_second;
    logic [15:0] tick_reload;
    logic [7:0]  blink_half_period;
  } cfg_t;

  // Time and mode as seen by the display decoder.
  typedef struct packed {
    logic [5:0] minutes;
    logic [4:0] hours;
    logic       setting;
    logic [1:0] field;
    logic       blank;
  } view_t;

  typedef struct packed {
    logic [6:0] seg_minute_ones;
    logic [6:0] seg_minute_tens;
    logic [6:0] seg_hour_ones;
    logic [6:0] seg_hour_tens;
    logic       setting_active;
    logic [1:0] field_selected;
  } res_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } dec_t;

  // Seven-segment pattern of one decimal digit; non-decimal codes are dark.
  function automatic logic [6:0] seg_of(logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7c;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Splits a value below 64 into tens and ones digits.
  function automatic dec_t split_dec(logic [5:0] v);
    dec_t       r;
    logic [5:0] tens_x10;
    logic [5:0] diff;
    if (v >= 6'd60) begin
      r.tens = 3'd6;
    end else if (v >= 6'd50) begin
      r.tens = 3'd5;
    end else if (v >= 6'd40) begin
      r.tens = 3'd4;
    end else if (v >= 6'd30) begin
      r.tens = 3'd3;
    end else if (v >= 6'd20) begin
      r.tens = 3'd2;
    end else if (v >= 6'd10) begin
      r.tens = 3'd1;
    end else begin
      r.tens = 3'd0;
    end
    tens_x10 = {3'b000, r.tens} * 6'd10;
    diff = v - tens_x10;
    r.ones = diff[3:0];
    return r;
  endfunction

endpackage

@@ rtl/clk24_seg.sv @@
// Seven-segment decode of minutes and hours with blanking of the field being set.
module clk24_seg (
  input  clk24_pkg::view_t view_i,
  output clk24_pkg::res_t  res_o
);

  clk24_pkg::dec_t min_dec;
  clk24_pkg::dec_t hr_dec;
  logic            blank_min;
  logic            blank_hr;

  always_comb begin
    min_dec = clk24_pkg::split_dec(view_i.minutes);
    hr_dec  = clk24_pkg::split_dec({1'b0, view_i.hours});
    blank_min = view_i.blank && (view_i.field == clk24_pkg::FieldMinutes);
    blank_hr  = view_i.blank && (view_i.field == clk24_pkg::FieldHours);

    res_o.seg_minute_ones = blank_min ? 7'h00 : clk24_pkg::seg_of(min_dec.ones);
    res_o.seg_minute_tens = blank_min ? 7'h00 : clk24_pkg::seg_of({1'b0, min_dec.tens});
    res_o.seg_hour_ones   = blank_hr  ? 7'h00 : clk24_pkg::seg_of(hr_dec.ones);
    res_o.seg_hour_tens   = blank_hr  ? 7'h00 : clk24_pkg::seg_of({1'b0, hr_dec.tens});
    res_o.setting_active  = view_i.setting;
    res_o.field_selected  = view_i.setting ? view_i.field : clk24_pkg::FieldNone;
  end

endmodule

@@ rtl/clk24_time.sv @@
// Timekeeping, set mode, up-edge detection and blink phase state of the clock.
`include "clock_24h_seven_segment_with_set_top_assert.svh"

module clk24_time (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             tick_i,
  input  logic             select_press_i,
  input  logic             up_button_i,
  input  logic             enter_button_i,
  input  clk24_pkg::cfg_t  cfg_i,
  output clk24_pkg::view_t view_o
);

  logic [15:0] tick_count_q, tick_count_d;
  logic [5:0]  seconds_q, seconds_d;
  logic [5:0]  minutes_q, minutes_d;
  logic [4:0]  hours_q, hours_d;
  logic        set_q, set_d;
  logic [1:0]  field_q, field_d;
  logic [7:0]  blink_count_q, blink_count_d;
  logic        blink_off_q, blink_off_d;
  logic        up_seen_q;
  logic        blink_off_shown;
  logic [15:0] tick_inc;

  always_comb begin
    tick_count_d  = tick_count_q;
    seconds_d     = seconds_q;
    minutes_d     = minutes_q;
    hours_d       = hours_q;
    set_d         = set_q;
    field_d       = field_q;
    blink_count_d = blink_count_q;
    blink_off_d   = blink_off_q;
    tick_inc      = (tick_count_q != 16'hFFFF) ? tick_count_q + 16'd1 : tick_count_q;

    // The clock runs only when the beat starts outside set mode.
    if (!set_q && tick_i) begin
      tick_count_d = tick_inc;
      if (tick_inc >= cfg_i.ticks_per_second) begin
        tick_count_d = cfg_i.tick_reload;
        seconds_d = seconds_q + 6'd1;
        if (seconds_d >= clk24_pkg::SecondsPerMinute) begin
          seconds_d = 6'd0;
          minutes_d = minutes_q + 6'd1;
        end
        if (minutes_d >= clk24_pkg::MinutesPerHour) begin
          minutes_d = 6'd0;
          hours_d = hours_q + 5'd1;
        end
        if (hours_d >= clk24_pkg::HoursPerDay) begin
          hours_d = 5'd0;
        end
      end
    end

    if (enter_button_i) begin
      set_d = 1'b0;
    end

    if (select_press_i) begin
      if (!set_d) begin
        set_d         = 1'b1;
        blink_count_d = 8'd0;
        blink_off_d   = 1'b0;
      end
      field_d = (field_q == clk24_pkg::FieldMinutes) ? clk24_pkg::FieldHours
                                                     : clk24_pkg::FieldMinutes;
    end

    // Set-mode advance wraps without carrying into the next field.
    if (set_d && up_button_i && !up_seen_q) begin
      if (field_d == clk24_pkg::FieldMinutes) begin
        minutes_d = (minutes_d >= 6'd59) ? 6'd0 : minutes_d + 6'd1;
      end else if (field_d == clk24_pkg::FieldHours) begin
        hours_d = (hours_d >= 5'd23) ? 5'd0 : hours_d + 5'd1;
      end
    end

    // The display takes the blink phase before this beat advances it.
    blink_off_shown = blink_off_d;

    if (set_d) begin
      blink_count_d = blink_count_d + 8'd1;
      if (blink_count_d >= cfg_i.blink_half_period) begin
        blink_count_d = 8'd0;
        blink_off_d   = !blink_off_d;
      end
    end

    view_o.minutes = minutes_d;
    view_o.hours   = hours_d;
    view_o.setting = set_d;
    view_o.field   = field_d;
    view_o.blank   = set_d && blink_off_shown;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q  <= 16'd0;
      seconds_q     <= 6'd0;
      minutes_q     <= 6'd0;
      hours_q       <= 5'd0;
      set_q         <= 1'b0;
      field_q       <= clk24_pkg::FieldNone;
      blink_count_q <= 8'd0;
      blink_off_q   <= 1'b0;
      up_seen_q     <= 1'b0;
    end else if (accept_i) begin
      tick_count_q  <= tick_count_d;
      seconds_q     <= seconds_d;
      minutes_q     <= minutes_d;
      hours_q       <= hours_d;
      set_q         <= set_d;
      field_q       <= field_d;
      blink_count_q <= blink_count_d;
      blink_off_q   <= blink_off_d;
      up_seen_q     <= up_button_i;
    end
  end

  `CLK24_ASSERT(a_seconds_range, seconds_q < clk24_pkg::SecondsPerMinute, "seconds out of range")
  `CLK24_ASSERT(a_minutes_range, minutes_q < clk24_pkg::MinutesPerHour, "minutes out of range")
  `CLK24_ASSERT(a_hours_range, hours_q < clk24_pkg::HoursPerDay, "hours out of range")
  `CLK24_ASSERT(a_set_has_field, set_q |-> (field_q != clk24_pkg::FieldNone), "no field in set mode")

endmodule

@@ rtl/clock_24h_seven_segment_with_set_top.sv @@
// An accepted beat's result is registered in the main output entry, or in the skid entry while the main one stalls.
// Throughput: one beat per cycle while in_stall_o is low; the state update is a single pass of counter logic.
// A two-entry output buffer lets one more beat in while a result waits under stall.
// Reset clears the time to 00:00:00, leaves set mode and restores register defaults.
`include "clock_24h_seven_segment_with_set_top_assert.svh"

module clock_24h_seven_segment_with_set_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        tick_i,
  input  logic        select_press_i,
  input  logic        up_button_i,
  input  logic        enter_button_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  seg_minute_ones_o,
  output logic [6:0]  seg_minute_tens_o,
  output logic [6:0]  seg_hour_ones_o,
  output logic [6:0]  seg_hour_tens_o,
  output logic        setting_active_o,
  output logic [1:0]  field_selected_o
);

  clk24_pkg::cfg_t  cfg_q;
  clk24_pkg::view_t view;
  clk24_pkg::res_t  res;
  clk24_pkg::res_t  main_q;
  clk24_pkg::res_t  skid_q;
  logic             main_valid_q;
  logic             skid_valid_q;
  logic             accept;
  logic             out_fire;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_fire = main_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second  <= clk24_pkg::TicksPerSecondReset;
      cfg_q.tick_reload       <= clk24_pkg::TickReloadReset;
      cfg_q.blink_half_period <= clk24_pkg::BlinkHalfReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        clk24_pkg::CfgTicksPerSecond: cfg_q.ticks_per_second  <= cfg_wdata_i;
        clk24_pkg::CfgTickReload:     cfg_q.tick_reload       <= cfg_wdata_i;
        clk24_pkg::CfgBlinkHalf:      cfg_q.blink_half_period <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  clk24_time u_time (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .tick_i         (tick_i),
    .select_press_i (select_press_i),
    .up_button_i    (up_button_i),
    .enter_button_i (enter_button_i),
    .cfg_i          (cfg_q),
    .view_o         (view)
  );

  clk24_seg u_seg (
    .view_i (view),
    .res_o  (res)
  );

  // The skid entry only fills when the main entry holds a stalled beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || out_fire) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (accept) begin
        main_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign in_stall_o        = skid_valid_q;
  assign out_valid_o       = main_valid_q;
  assign seg_minute_ones_o = main_q.seg_minute_ones;
  assign seg_minute_tens_o = main_q.seg_minute_tens;
  assign seg_hour_ones_o   = main_q.seg_hour_ones;
  assign seg_hour_tens_o   = main_q.seg_hour_tens;
  assign setting_active_o  = main_q.setting_active;
  assign field_selected_o  = main_q.field_selected;

  `CLK24_ASSERT_ALWAYS(a_skid_needs_main, skid_valid_q |-> main_valid_q, "skid entry full with main entry empty")
  `CLK24_ASSERT(a_stalled_accept_skids, (main_valid_q && out_stall_i && accept) |=> skid_valid_q, "beat accepted under stall was not buffered")
  `CLK24_ASSERT(a_field_zero_idle, (out_valid_o && !setting_active_o) |-> (field_selected_o == clk24_pkg::FieldNone), "field shown outside set mode")

endmodule

@@ tb/clock_24h_seven_segment_with_set_top_tb.sv @@
// Self-checking testbench of the 24-hour seven-segment clock with set mode.
module clock_24h_seven_segment_with_set_top_tb;

  localparam int HangLimit  = 5000;
  localparam int PhaseItems = 95;
  localparam int NumPhases  = 8;
  localparam int NumRows    = 26;

  typedef struct packed {
    logic            tick;
    logic            sel;
    logic            up;
    logic            enter;
    logic            known;
    clk24_pkg::res_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = clk24_pkg::CfgTicksPerSecond;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        tick_i = 1'b0;
  logic        select_press_i = 1'b0;
  logic        up_button_i = 1'b0;
  logic        enter_button_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  seg_minute_ones_o;
  logic [6:0]  seg_minute_tens_o;
  logic [6:0]  seg_hour_ones_o;
  logic [6:0]  seg_hour_tens_o;
  logic        setting_active_o;
  logic [1:0]  field_selected_o;

  clock_24h_seven_segment_with_set_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .tick_i            (tick_i),
    .select_press_i    (select_press_i),
    .up_button_i       (up_button_i),
    .enter_button_i    (enter_button_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .seg_minute_ones_o (seg_minute_ones_o),
    .seg_minute_tens_o (seg_minute_tens_o),
    .seg_hour_ones_o   (seg_hour_ones_o),
    .seg_hour_tens_o   (seg_hour_tens_o),
    .setting_active_o  (setting_active_o),
    .field_selected_o  (field_selected_o)
  );

  always #6 clk_i = ~clk_i;

  // Register copies and clock state of the predictor.
  logic [15:0] cfg_tps = clk24_pkg::TicksPerSecondReset;
  logic [15:0] cfg_reload = clk24_pkg::TickReloadReset;
  logic [7:0]  cfg_blink = clk24_pkg::BlinkHalfReset;
  logic [15:0] tick_cnt = 16'd0;
  logic [5:0]  sec = 6'd0;
  logic [5:0]  min = 6'd0;
  logic [4:0]  hr = 5'd0;
  logic        setting = 1'b0;
  logic [1:0]  field = clk24_pkg::FieldNone;
  logic [7:0]  blink_cnt = 8'd0;
  logic        blink_dark = 1'b0;
  logic        up_prev = 1'b0;

  clk24_pkg::res_t display_q[$];
  stim_row_t       directed_rows[NumRows];
  logic            known_pending = 1'b0;
  clk24_pkg::res_t known_res = '0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              err_count = 0;
  int              n_sent = 0;
  int              n_checked = 0;
  int              n_settings = 0;
  int              n_set_results = 0;
  int              n_dark = 0;
  int              n_wraps = 0;
  int              quiet_cycles = 0;

  function automatic logic [6:0] digit_seg(int d);
    case (d)
      0:       return 7'h3f;
      1:       return 7'h06;
      2:       return 7'h5b;
      3:       return 7'h4f;
      4:       return 7'h66;
      5:       return 7'h6d;
      6:       return 7'h7c;
      7:       return 7'h07;
      8:       return 7'h7f;
      9:       return 7'h67;
      default: return 7'h00;
    endcase
  endfunction

  // Advances the clock by one input beat and returns the display it shows.
  function automatic clk24_pkg::res_t clock_step(logic t, logic s, logic u, logic e);
    clk24_pkg::res_t r;
    logic            up_rise;
    up_rise = u && !up_prev;
    if (!setting && t) begin
      if (tick_cnt != 16'hffff) tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= cfg_tps) begin
        tick_cnt = cfg_reload;
        sec = sec + 6'd1;
        if (sec >= clk24_pkg::SecondsPerMinute) begin
          sec = 6'd0;
          min = min + 6'd1;
        end
        if (min >= clk24_pkg::MinutesPerHour) begin
          min = 6'd0;
          hr = hr + 5'd1;
        end
        if (hr >= clk24_pkg::HoursPerDay) hr = 5'd0;
      end
    end
    // Enter is applied before select, so both together re-enter set mode.
    if (e) setting = 1'b0;
    if (s) begin
      if (!setting) begin
        setting = 1'b1;
        blink_cnt = 8'd0;
        blink_dark = 1'b0;
      end
      field = (field == clk24_pkg::FieldMinutes) ? clk24_pkg::FieldHours
                                                 : clk24_pkg::FieldMinutes;
    end
    if (setting && up_rise) begin
      if (field == clk24_pkg::FieldMinutes) begin
        if (min >= 6'd59) n_wraps++;
        min = (min >= 6'd59) ? 6'd0 : min + 6'd1;
      end else if (field == clk24_pkg::FieldHours) begin
        if (hr >= 5'd23) n_wraps++;
        hr = (hr >= 5'd23) ? 5'd0 : hr + 5'd1;
      end
    end
    up_prev = u;
    r.seg_minute_ones = digit_seg(min % 10);
    r.seg_minute_tens = digit_seg(min / 10);
    r.seg_hour_ones   = digit_seg(hr % 10);
    r.seg_hour_tens   = digit_seg(hr / 10);
    if (setting && blink_dark) begin
      n_dark++;
      if (field == clk24_pkg::FieldMinutes) begin
        r.seg_minute_ones = 7'h00;
        r.seg_minute_tens = 7'h00;
      end else if (field == clk24_pkg::FieldHours) begin
        r.seg_hour_ones = 7'h00;
        r.seg_hour_tens = 7'h00;
      end
    end
    r.setting_active = setting;
    r.field_selected = setting ? field : clk24_pkg::FieldNone;
    if (setting) begin
      n_set_results++;
      blink_cnt = blink_cnt + 8'd1;
      if (blink_cnt >= cfg_blink) begin
        blink_cnt = 8'd0;
        blink_dark = ~blink_dark;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Predicts on every accepted input beat, then checks every accepted result beat.
  always @(posedge clk_i) begin : scoreboard
    clk24_pkg::res_t want;
    clk24_pkg::res_t got;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && !in_stall_o) begin
        want = clock_step(tick_i, select_press_i, up_button_i, enter_button_i);
        display_q.push_back(known_pending ? known_res : want);
        quiet_cycles = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles = 0;
        got = '{seg_minute_ones_o, seg_minute_tens_o, seg_hour_ones_o, seg_hour_tens_o,
                setting_active_o, field_selected_o};
        if (display_q.size() == 0) begin
          err_count++;
          $display("%0t: result beat with no input pending, actual %h", $time, got);
        end else begin
          want = display_q.pop_front();
          n_checked++;
          check_field("seg_minute_ones", want.seg_minute_ones, got.seg_minute_ones);
          check_field("seg_minute_tens", want.seg_minute_tens, got.seg_minute_tens);
          check_field("seg_hour_ones", want.seg_hour_ones, got.seg_hour_ones);
          check_field("seg_hour_tens", want.seg_hour_tens, got.seg_hour_tens);
          check_field("setting_active", 7'(want.setting_active), 7'(got.setting_active));
          check_field("field_selected", 7'(want.field_selected), 7'(got.field_selected));
        end
      end
      if (quiet_cycles >= HangLimit) begin
        $display("Timeout after %0d cycles without a beat", quiet_cycles);
        $display("clock_24h_seven_segment_with_set_top test failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(logic t, logic s, logic u, logic e,
                           logic known = 1'b0, clk24_pkg::res_t res = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i     <= 1'b0;
      tick_i         <= 1'($urandom_range(0, 1));
      select_press_i <= 1'($urandom_range(0, 1));
      up_button_i    <= 1'($urandom_range(0, 1));
      enter_button_i <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    known_pending = known;
    known_res = res;
    in_valid_i     <= 1'b1;
    tick_i         <= t;
    select_press_i <= s;
    up_button_i    <= u;
    enter_button_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (display_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic program_regs(logic [15:0] tps, logic [15:0] reload, logic [7:0] blink);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= clk24_pkg::CfgTicksPerSecond;
    cfg_wdata_i <= tps;
    @(negedge clk_i);
    cfg_addr_i  <= clk24_pkg::CfgTickReload;
    cfg_wdata_i <= reload;
    @(negedge clk_i);
    cfg_addr_i  <= clk24_pkg::CfgBlinkHalf;
    cfg_wdata_i <= {8'h00, blink};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_tps = tps;
    cfg_reload = reload;
    cfg_blink = blink;
    n_settings++;
  endtask

  // Normal running with ticks and an up level that wanders.
  task automatic run_timekeeping();
    int   n;
    logic lvl;
    n = $urandom_range(1, 20);
    lvl = 1'($urandom_range(0, 1));
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) lvl = ~lvl;
      send_beat($urandom_range(0, 99) < 75, 1'b0, lvl, $urandom_range(0, 99) < 3);
    end
  endtask

  // Enter set mode, pick a field, pulse up a number of times, then leave.
  task automatic run_set_session();
    int pulses;
    send_beat(1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
    if ($urandom_range(0, 1) == 1) send_beat(1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
    pulses = ($urandom_range(0, 99) < 20) ? $urandom_range(24, 70) : $urandom_range(0, 12);
    repeat (pulses) begin
      send_beat(1'($urandom_range(0, 1)), $urandom_range(0, 99) < 4, 1'b1, 1'b0);
      repeat ($urandom_range(1, 2)) send_beat(1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
    end
    send_beat(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
              1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 5)) begin
      send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic stim_row_t plain_row(logic t, logic s, logic u, logic e);
    return '{t, s, u, e, 1'b0, clk24_pkg::res_t'('0)};
  endfunction

  function automatic stim_row_t known_row(logic t, logic s, logic u, logic e,
                                          clk24_pkg::res_t r);
    return '{t, s, u, e, 1'b1, r};
  endfunction

  initial begin
    int   target;
    int   pick;
    int   tps_r;
    logic paused;

    directed_rows = '{
      known_row(0, 0, 0, 0, '{7'h3f, 7'h3f, 7'h3f, 7'h3f, 1'b0, clk24_pkg::FieldNone}),
      known_row(1, 0, 0, 0, '{7'h3f, 7'h3f, 7'h3f, 7'h3f, 1'b0, clk24_pkg::FieldNone}),
      // An up edge outside set mode changes nothing.
      known_row(0, 0, 1, 0, '{7'h3f, 7'h3f, 7'h3f, 7'h3f, 1'b0, clk24_pkg::FieldNone}),
      plain_row(0, 0, 0, 0),
      known_row(0, 1, 0, 0, '{7'h3f, 7'h3f, 7'h3f, 7'h3f, 1'b1, clk24_pkg::FieldMinutes}),
      plain_row(1, 0, 0, 0),
      known_row(0, 0, 1, 0, '{7'h06, 7'h3f, 7'h3f, 7'h3f, 1'b1, clk24_pkg::FieldMinutes}),
      plain_row(0, 0, 1, 0),
      plain_row(0, 0, 0, 0),
      plain_row(0, 1, 0, 0),
      plain_row(0, 0, 1, 0),
      plain_row(1, 0, 0, 0),
      plain_row(0, 0, 0, 1),
      plain_row(0, 1, 0, 1),
      plain_row(0, 1, 0, 1),
      // Ticks held in set mode until the hour digits go dark.
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(1, 0, 0, 0),
      plain_row(0, 0, 0, 0),
      plain_row(1, 1, 1, 1)
    };

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          for (int i = 0; i < NumRows; i++) begin
            send_beat(directed_rows[i].tick, directed_rows[i].sel, directed_rows[i].up,
                      directed_rows[i].enter, directed_rows[i].known, directed_rows[i].res);
          end
        end
        1: program_regs(16'd1, 16'd0, 8'd1);
        2: program_regs(16'd0, 16'd0, 8'd0);
        3: program_regs(16'hffff, 16'hffff, 8'hff);
        4: program_regs(16'd2, 16'hffff, 8'd3);
        5: begin
          tps_r = $urandom_range(1, 50);
          program_regs(16'(tps_r), 16'($urandom_range(0, tps_r - 1)),
                       8'($urandom_range(1, 20)));
        end
        6: program_regs(16'd5, 16'd5, 8'd2);
        default: program_regs(16'd3, 16'd1, 8'd7);
      endcase
      known_pending = 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      target = n_sent + PhaseItems;
      paused = 1'b0;
      while (n_sent < target) begin
        // Halfway through, hold off until every pending result is out.
        if (!paused && n_sent >= target - PhaseItems / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) run_timekeeping();
        else if (pick < 85) run_set_session();
        else run_noise();
      end
    end

    wait_drained();
    $display("Sent %0d input beats under %0d register settings and four idle mixes;",
             n_sent, n_settings + 1);
    $display("%0d results checked, %0d in set mode, %0d with the selected digits dark,",
             n_checked, n_set_results, n_dark);
    $display("%0d field wraps.", n_wraps);
    if (err_count == 0 && display_q.size() == 0) begin
      $display("clock_24h_seven_segment_with_set_top test passed");
    end else begin
      $display("clock_24h_seven_segment_with_set_top test failed");
    end
    $finish;
  end

endmodule
